// ===== design/tvrl_pkg.sv =====
// Package for the teleop velocity ramp limiter: widths, scaling constants,
// register indexes, datapath command codes and controller states.
// No dependencies; every other file of the block imports it.
package tvrl_pkg;

  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int VEL_W      = 32;
  localparam int LIMIT_W    = 31;
  localparam int BOOST_W    = 12;
  localparam int STICK_W    = 16;
  localparam int CMD_W      = 16;
  localparam int WAIT_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [AXIS_W-1:0] AXIS_FWD  = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAT  = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_TURN = 2'd2;

  // Boost factor of one in unsigned Q4.8.
  localparam logic [BOOST_W-1:0] BOOST_ONE       = 12'd256;
  localparam logic [BOOST_W-1:0] RUN_BOOST_RESET = 12'd384;

  // Q16.16 to mm/s is a multiply by 1000 and a shift by 16.
  localparam logic [31:0] MM_SCALE = 32'd1000;
  // Q16.16 to deg/s: v*18000 / (628*65536) reduces to v*4500 / (157*65536).
  localparam logic [31:0] DEG_SCALE       = 32'd4500;
  localparam int          DEG_DIV         = 157;
  localparam int          DEG_RECIP_SHIFT = 36;
  localparam logic [31:0] DEG_RECIP = 32'((64'd1 << DEG_RECIP_SHIFT) / DEG_DIV);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREE_AXIS     = 3'd0,
    CFG_RUN_BOOST      = 3'd1,
    CFG_MAX_VEL_FWD    = 3'd2,
    CFG_MAX_VEL_LAT    = 3'd3,
    CFG_MAX_VEL_TURN   = 3'd4,
    CFG_MAX_STEP_FWD   = 3'd5,
    CFG_MAX_STEP_LAT   = 3'd6,
    CFG_MAX_STEP_TURN  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_IN,
    DP_SET_BOOST,
    DP_TGT_MUL1,
    DP_TGT_MUL2,
    DP_TGT_SAT,
    DP_CLEAR_ALL,
    DP_RAMP,
    DP_CNV_MUL,
    DP_CNV_MM,
    DP_CNV_RCP,
    DP_CNV_Q0,
    DP_CNV_DEG,
    DP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [AXIS_W-1:0]   axis;
  } dp_cmd_t;

  typedef struct packed {
    logic req_type;
    logic deadman_pressed;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TGT_MUL1,
    S_TGT_MUL2,
    S_TGT_SAT,
    S_RAMP,
    S_CNV_MUL,
    S_CNV_MM,
    S_CNV_RCP,
    S_CNV_Q0,
    S_CNV_DEG,
    S_EMIT
  } ctrl_state_e;

endpackage

// ===== design/tvrl_if.sv =====
// Channel interfaces of the teleop velocity ramp limiter: request, response
// and configuration write. Depends on tvrl_pkg.

interface tvrl_req_if import tvrl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic                      deadman_pressed;
  logic                      run_pressed;
  logic signed [STICK_W-1:0] stick_forward;
  logic signed [STICK_W-1:0] stick_lateral;
  logic signed [STICK_W-1:0] stick_turn;

  modport source (
    output valid, req_type, deadman_pressed, run_pressed,
    output stick_forward, stick_lateral, stick_turn,
    input  ready
  );
  modport sink (
    input  valid, req_type, deadman_pressed, run_pressed,
    input  stick_forward, stick_lateral, stick_turn,
    output ready
  );
endinterface

interface tvrl_rsp_if import tvrl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] ramp_forward;
  logic signed [VEL_W-1:0] ramp_lateral;
  logic signed [VEL_W-1:0] ramp_turn;
  logic signed [CMD_W-1:0] cmd_forward_mm;
  logic signed [CMD_W-1:0] cmd_lateral_mm;
  logic signed [CMD_W-1:0] cmd_turn_deg;
  logic                    lateral_present;

  modport source (
    output valid, ramp_forward, ramp_lateral, ramp_turn,
    output cmd_forward_mm, cmd_lateral_mm, cmd_turn_deg, lateral_present,
    input  ready
  );
  modport sink (
    input  valid, ramp_forward, ramp_lateral, ramp_turn,
    input  cmd_forward_mm, cmd_lateral_mm, cmd_turn_deg, lateral_present,
    output ready
  );
endinterface

interface tvrl_cfg_if import tvrl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tvrl_dp.sv =====
// Datapath of the teleop velocity ramp limiter: configuration registers,
// target and ramp state, one shared 32x32 multiplier and the result register.
// Depends on tvrl_pkg and tvrl_if; driven by commands from tvrl_ctrl.
module tvrl_dp import tvrl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  tvrl_req_if.sink       req_i,
  tvrl_rsp_if.source     rsp_o,
  tvrl_cfg_if.sink       cfg_i,
  input  dp_cmd_t        cmd_i,
  output dp_status_t     status_o
);

  function automatic logic [CMD_W-1:0] sat16(input logic neg, input logic [31:0] mag);
    logic [CMD_W-1:0] res;
    if (!neg) begin
      res = (mag > 32'd32767) ? 16'h7FFF : mag[CMD_W-1:0];
    end else begin
      res = (mag > 32'd32768) ? 16'h8000 : CMD_W'(~mag[CMD_W-1:0] + 16'd1);
    end
    return res;
  endfunction

  // Configuration.
  logic                three_axis_q;
  logic [BOOST_W-1:0]  run_boost_q;
  logic [LIMIT_W-1:0]  max_vel_q  [AXES];
  logic [LIMIT_W-1:0]  max_step_q [AXES];

  // Block state.
  logic [BOOST_W-1:0]  boost_q;
  logic [VEL_W-1:0]    target_q [AXES];
  logic [VEL_W-1:0]    ramp_q   [AXES];

  // Latched request and working registers.
  logic                req_type_q, deadman_q, run_q;
  logic [STICK_W-1:0]  stick_q [AXES];
  logic [63:0]         mul_q;
  logic                sign_q;
  logic [27:0]         m_q;
  logic [20:0]         q0_q;
  logic [CMD_W-1:0]    cmd_q [AXES];

  // Result register.
  logic [VEL_W-1:0]    out_ramp_q [AXES];
  logic [CMD_W-1:0]    out_cmd_q  [AXES];
  logic                out_lat_q;

  logic [AXIS_W-1:0]   ax;
  logic [STICK_W-1:0]  stick_sel, stick_mag;
  logic [VEL_W-1:0]    tgt_sel, rmp_sel, rmp_mag;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;
  logic [35:0]         tmag;
  logic [VEL_W-1:0]    tsat;
  logic signed [32:0]  diff, step_pos, step_neg;
  logic [VEL_W-1:0]    ramp_next;
  logic                lat_off;
  logic [28:0]         deg_rem;
  logic [21:0]         deg_q;

  assign ax        = cmd_i.axis;
  assign lat_off   = (ax == AXIS_LAT) && !three_axis_q;
  assign stick_sel = stick_q[ax];
  assign stick_mag = stick_sel[STICK_W-1] ? (~stick_sel + 16'd1) : stick_sel;
  assign tgt_sel   = target_q[ax];
  assign rmp_sel   = ramp_q[ax];
  assign rmp_mag   = rmp_sel[VEL_W-1] ? (~rmp_sel + 32'd1) : rmp_sel;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      DP_TGT_MUL1: begin
        mul_a = {16'd0, stick_mag};
        mul_b = {20'd0, boost_q};
      end
      DP_TGT_MUL2: begin
        mul_a = {4'd0, mul_q[27:0]};
        mul_b = {1'b0, max_vel_q[ax]};
      end
      DP_CNV_MUL: begin
        mul_a = rmp_mag;
        mul_b = (ax == AXIS_TURN) ? DEG_SCALE : MM_SCALE;
      end
      DP_CNV_RCP: begin
        mul_a = {4'd0, mul_q[43:16]};
        mul_b = DEG_RECIP;
      end
      DP_CNV_Q0: begin
        mul_a = {11'd0, mul_q[56:36]};
        mul_b = 32'(DEG_DIV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Target: magnitude shifted by 23 truncates toward zero, then saturate.
  assign tmag = mul_q[58:23];
  always_comb begin
    if (!stick_sel[STICK_W-1]) begin
      tsat = (tmag > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tmag[VEL_W-1:0];
    end else begin
      tsat = (tmag > 36'h0_8000_0000) ? 32'h8000_0000 : (~tmag[VEL_W-1:0] + 32'd1);
    end
  end

  // Slew limit of one axis.
  assign diff     = $signed({tgt_sel[VEL_W-1], tgt_sel}) - $signed({rmp_sel[VEL_W-1], rmp_sel});
  assign step_pos = $signed({2'b00, max_step_q[ax]});
  assign step_neg = -step_pos;
  always_comb begin
    if (diff > step_pos) begin
      ramp_next = rmp_sel + {1'b0, max_step_q[ax]};
    end else if (diff < step_neg) begin
      ramp_next = rmp_sel - {1'b0, max_step_q[ax]};
    end else begin
      ramp_next = tgt_sel;
    end
  end

  // Reciprocal quotient is low by at most one; one compare fixes it.
  assign deg_rem = {1'b0, m_q} - mul_q[28:0];
  assign deg_q   = {1'b0, q0_q} + {21'd0, (deg_rem >= 29'(DEG_DIV))};

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_axis_q <= 1'b1;
      run_boost_q  <= RUN_BOOST_RESET;
      boost_q      <= BOOST_ONE;
      for (int k = 0; k < AXES; k++) begin
        max_vel_q[k]  <= '0;
        max_step_q[k] <= '0;
        target_q[k]   <= '0;
        ramp_q[k]     <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_THREE_AXIS:    three_axis_q       <= cfg_i.data[0];
          CFG_RUN_BOOST:     run_boost_q        <= cfg_i.data[BOOST_W-1:0];
          CFG_MAX_VEL_FWD:   max_vel_q[0]       <= cfg_i.data[LIMIT_W-1:0];
          CFG_MAX_VEL_LAT:   max_vel_q[1]       <= cfg_i.data[LIMIT_W-1:0];
          CFG_MAX_VEL_TURN:  max_vel_q[2]       <= cfg_i.data[LIMIT_W-1:0];
          CFG_MAX_STEP_FWD:  max_step_q[0]      <= cfg_i.data[LIMIT_W-1:0];
          CFG_MAX_STEP_LAT:  max_step_q[1]      <= cfg_i.data[LIMIT_W-1:0];
          CFG_MAX_STEP_TURN: max_step_q[2]      <= cfg_i.data[LIMIT_W-1:0];
        endcase
      end
      unique case (cmd_i.op)
        DP_SET_BOOST: boost_q <= run_q ? run_boost_q : BOOST_ONE;
        DP_TGT_SAT:   target_q[ax] <= lat_off ? '0 : tsat;
        DP_CLEAR_ALL: begin
          for (int k = 0; k < AXES; k++) begin
            target_q[k] <= '0;
            ramp_q[k]   <= '0;
          end
        end
        DP_RAMP: begin
          if (lat_off) begin
            target_q[ax] <= '0;
            ramp_q[ax]   <= '0;
          end else begin
            ramp_q[ax]   <= ramp_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD_IN: begin
        req_type_q <= req_i.req_type;
        deadman_q  <= req_i.deadman_pressed;
        run_q      <= req_i.run_pressed;
        stick_q[0] <= req_i.stick_forward;
        stick_q[1] <= req_i.stick_lateral;
        stick_q[2] <= req_i.stick_turn;
      end
      DP_TGT_MUL1, DP_TGT_MUL2: mul_q <= mul_p;
      DP_CNV_MUL: begin
        mul_q  <= mul_p;
        sign_q <= rmp_sel[VEL_W-1];
      end
      DP_CNV_MM: cmd_q[ax] <= sat16(sign_q, {6'd0, mul_q[41:16]});
      DP_CNV_RCP: begin
        mul_q <= mul_p;
        m_q   <= mul_q[43:16];
      end
      DP_CNV_Q0: begin
        mul_q <= mul_p;
        q0_q  <= mul_q[56:36];
      end
      DP_CNV_DEG: cmd_q[AXIS_TURN] <= sat16(sign_q, {10'd0, deg_q});
      DP_LOAD_OUT: begin
        for (int k = 0; k < AXES; k++) begin
          out_ramp_q[k] <= ramp_q[k];
          out_cmd_q[k]  <= cmd_q[k];
        end
        out_lat_q <= three_axis_q;
      end
      default: ;
    endcase
  end

  assign status_o.req_type        = req_type_q;
  assign status_o.deadman_pressed = deadman_q;

  assign rsp_o.ramp_forward    = out_ramp_q[0];
  assign rsp_o.ramp_lateral    = out_ramp_q[1];
  assign rsp_o.ramp_turn       = out_ramp_q[2];
  assign rsp_o.cmd_forward_mm  = out_cmd_q[0];
  assign rsp_o.cmd_lateral_mm  = out_cmd_q[1];
  assign rsp_o.cmd_turn_deg    = out_cmd_q[2];
  assign rsp_o.lateral_present = out_lat_q;

endmodule

// ===== design/tvrl_ctrl.sv =====
// Controller of the teleop velocity ramp limiter: sequences the datapath over
// the three axes and holds the activity, stop and start-up wait flags.
// Depends on tvrl_pkg.
module tvrl_ctrl import tvrl_pkg::*; #(
  parameter int INIT_WAIT_TICKS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o
);

  ctrl_state_e         state_q, state_d;
  logic [AXIS_W-1:0]   axis_q, axis_d;
  logic                active_q, active_d;
  logic                stopped_q, stopped_d;
  logic                init_done_q, init_done_d;
  logic [WAIT_W-1:0]   wait_count_q, wait_count_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= AXIS_FWD;
      active_q     <= 1'b0;
      stopped_q    <= 1'b0;
      init_done_q  <= 1'b0;
      wait_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      axis_q       <= axis_d;
      active_q     <= active_d;
      stopped_q    <= stopped_d;
      init_done_q  <= init_done_d;
      wait_count_q <= wait_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    active_d     = active_q;
    stopped_d    = stopped_q;
    init_done_d  = init_done_q;
    wait_count_d = wait_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o.op     = DP_NOP;
    cmd_o.axis   = axis_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        axis_d     = AXIS_FWD;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD_IN;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        if (!status_i.req_type) begin
          if (!status_i.deadman_pressed) begin
            active_d = 1'b0;
          end else begin
            if (!active_q) begin
              active_d    = 1'b1;
              init_done_d = 1'b0;
            end
            cmd_o.op = DP_SET_BOOST;
            state_d  = S_TGT_MUL1;
          end
        end else if (!active_q) begin
          // First inactive tick since reset or the last active command: zero everything and send one stop.
          if (!stopped_q) begin
            cmd_o.op  = DP_CLEAR_ALL;
            stopped_d = 1'b1;
            state_d   = S_RAMP;
          end
        end else if (!init_done_q && (wait_count_q < WAIT_W'(INIT_WAIT_TICKS))) begin
          wait_count_d = wait_count_q + 1'b1;
        end else begin
          init_done_d = 1'b1;
          stopped_d   = 1'b0;
          state_d     = S_RAMP;
        end
      end
      S_TGT_MUL1: begin
        cmd_o.op = DP_TGT_MUL1;
        state_d  = S_TGT_MUL2;
      end
      S_TGT_MUL2: begin
        cmd_o.op = DP_TGT_MUL2;
        state_d  = S_TGT_SAT;
      end
      S_TGT_SAT: begin
        cmd_o.op = DP_TGT_SAT;
        if (axis_q == AXIS_TURN) begin
          state_d = S_IDLE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_TGT_MUL1;
        end
      end
      S_RAMP: begin
        cmd_o.op = DP_RAMP;
        if (axis_q == AXIS_TURN) begin
          axis_d  = AXIS_FWD;
          state_d = S_CNV_MUL;
        end else begin
          axis_d  = axis_q + 1'b1;
        end
      end
      S_CNV_MUL: begin
        cmd_o.op = DP_CNV_MUL;
        state_d  = (axis_q == AXIS_TURN) ? S_CNV_RCP : S_CNV_MM;
      end
      S_CNV_MM: begin
        cmd_o.op = DP_CNV_MM;
        axis_d   = axis_q + 1'b1;
        state_d  = S_CNV_MUL;
      end
      S_CNV_RCP: begin
        cmd_o.op = DP_CNV_RCP;
        state_d  = S_CNV_Q0;
      end
      S_CNV_Q0: begin
        cmd_o.op = DP_CNV_Q0;
        state_d  = S_CNV_DEG;
      end
      S_CNV_DEG: begin
        cmd_o.op = DP_CNV_DEG;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // The result register frees up in the same cycle it is taken.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/teleop_velocity_ramp_limiter.sv =====
// Top level of the teleop velocity ramp limiter: a controller and a datapath
// joined by a command struct and a status struct.
// Depends on tvrl_pkg, tvrl_if, tvrl_ctrl and tvrl_dp.
//
//   Channel  Direction  Transaction
//   req_i    in         joystick sample (req_type 0) or publish tick (req_type 1)
//   rsp_o    out        ramped velocities in Q16.16, mm/s and deg/s, at most one per tick
//   cfg_i    in         register write, index 0 to 7, always ready
//
// After a held-deadman sample come decode, two multiplier passes and a
// saturation per axis and the idle cycle. A tick that sends a command runs
// decode, three slew steps, multiply and mm scaling per linear axis,
// multiply, reciprocal, quotient and degree steps for the turn axis, the
// result load and idle. Other transactions only decode. Reset clears flags,
// targets and ramps at once; a waiting result stalls only the next load.
module teleop_velocity_ramp_limiter import tvrl_pkg::*; #(
  parameter int INIT_WAIT_TICKS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvrl_req_if.sink    req_i,
  tvrl_rsp_if.source  rsp_o,
  tvrl_cfg_if.sink    cfg_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;
  logic       out_valid;

  // The controller owns the request and response handshakes; the datapath owns every payload bit.
  tvrl_ctrl #(
    .INIT_WAIT_TICKS (INIT_WAIT_TICKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  tvrl_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .cfg_i    (cfg_i),
    .cmd_i    (dp_cmd),
    .status_o (dp_status)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

// ===== dv/teleop_velocity_ramp_limiter_test.sv =====
// Self-checking testbench for teleop_velocity_ramp_limiter: a directed table, then
// random joystick and tick traffic, checked against typed results and a cycle-free predictor.
// Depends on tvrl_pkg, the tvrl channel interfaces and the block's top level.
module teleop_velocity_ramp_limiter_test import tvrl_pkg::*; ();

  localparam int     INIT_WAIT     = 20;
  localparam int     N_REGS        = 2 ** CFG_IDX_W;
  localparam int     IDLE_PCT      = 19;
  localparam int     N_PHASES      = 6;
  localparam int     PER_PHASE     = 98;
  // This margin covers the longest transaction, a command tick, with room to spare.
  localparam int     SETTLE_CYCLES = 40;
  localparam int     CYCLE_LIMIT   = 300000;
  localparam int     N_DIR         = 16;

  localparam logic   REQ_SAMPLE = 1'b0;
  localparam logic   REQ_TICK   = 1'b1;

  localparam longint MM_PER_M  = 1000;
  localparam longint DEG_NUM   = 18000;
  localparam longint DEG_DEN   = 628;
  localparam longint Q16_ONE   = 65536;
  localparam longint TGT_SHIFT = 23;
  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;

  // One request transaction: a joystick sample or a publish tick.
  typedef struct {
    logic                      req_type;
    logic                      deadman_pressed;
    logic                      run_pressed;
    logic signed [STICK_W-1:0] stick_forward;
    logic signed [STICK_W-1:0] stick_lateral;
    logic signed [STICK_W-1:0] stick_turn;
  } joy_req_t;

  // One velocity command as it leaves the response channel.
  typedef struct {
    logic signed [VEL_W-1:0] ramp_forward;
    logic signed [VEL_W-1:0] ramp_lateral;
    logic signed [VEL_W-1:0] ramp_turn;
    logic signed [CMD_W-1:0] cmd_forward_mm;
    logic signed [CMD_W-1:0] cmd_lateral_mm;
    logic signed [CMD_W-1:0] cmd_turn_deg;
    logic                    lateral_present;
  } vel_cmd_t;

  // How a row of the directed table is checked. The typed kinds are results that
  // follow directly from the row: silence, an all-zero stop command, or every
  // axis pinned at positive full scale.
  typedef enum {CHK_PREDICT, CHK_SILENT, CHK_STOP_ZERO, CHK_FULL_POS} row_chk_e;

  typedef struct {
    int                        reps;
    logic                      req_type;
    logic                      deadman;
    logic                      run;
    logic signed [STICK_W-1:0] s_fwd;
    logic signed [STICK_W-1:0] s_lat;
    logic signed [STICK_W-1:0] s_turn;
    row_chk_e                  chk;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tvrl_req_if req_ch ();
  tvrl_rsp_if rsp_ch ();
  tvrl_cfg_if cfg_ch ();

  teleop_velocity_ramp_limiter #(
    .INIT_WAIT_TICKS(INIT_WAIT)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // Predictor copy of the registers and of the limiter state.
  logic                      cfg_three_axis;
  logic [BOOST_W-1:0]        cfg_run_boost;
  logic [LIMIT_W-1:0]        cfg_max_vel  [AXES];
  logic [LIMIT_W-1:0]        cfg_max_step [AXES];
  bit                        engaged;
  bit                        halted;
  bit                        warmed_up;
  logic [WAIT_W-1:0]         warmup_ticks;
  logic [BOOST_W-1:0]        boost_sel;
  logic signed [VEL_W-1:0]   vel_goal   [AXES];
  logic signed [VEL_W-1:0]   vel_ramped [AXES];

  // Commands predicted for accepted ticks, oldest first.
  vel_cmd_t pending_cmds [$];

  int       idle_pct = IDLE_PCT;
  int       mismatches = 0;
  int       cmds_seen = 0;
  int       cycles = 0;
  dir_row_t dir_tab [N_DIR];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [CMD_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[CMD_W-1:0];
  endfunction

  // Queues one expected command behind those already waiting.
  task automatic expect_cmd(input vel_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // Advances the predicted limiter by one accepted transaction. Returns 1 and
  // fills cmd when the transaction causes a velocity command.
  function automatic bit advance_limiter(input joy_req_t r, output vel_cmd_t cmd);
    longint stk [AXES];
    longint rv  [AXES];
    longint prod;
    longint vmax;
    longint bst;
    longint diff;
    longint lim;
    cmd = '{default: '0};
    if (r.req_type == REQ_SAMPLE) begin
      // A released deadman only drops activity; targets and boost stay.
      if (!r.deadman_pressed) begin
        engaged = 1'b0;
        return 1'b0;
      end
      if (!engaged) begin
        engaged   = 1'b1;
        warmed_up = 1'b0;
      end
      boost_sel = r.run_pressed ? cfg_run_boost : BOOST_ONE;
      stk[AXIS_FWD]  = r.stick_forward;
      stk[AXIS_LAT]  = r.stick_lateral;
      stk[AXIS_TURN] = r.stick_turn;
      bst = boost_sel;
      for (int k = 0; k < AXES; k++) begin
        if (k == AXIS_LAT && !cfg_three_axis) begin
          vel_goal[k] = '0;
        end else begin
          vmax = cfg_max_vel[k];
          prod = stk[k] * vmax * bst;
          prod = prod / (longint'(1) << TGT_SHIFT);
          if (prod > I32_MAX) prod = I32_MAX;
          if (prod < I32_MIN) prod = I32_MIN;
          vel_goal[k] = prod[VEL_W-1:0];
        end
      end
      return 1'b0;
    end

    if (!engaged) begin
      // After reset or an active command, the first inactive tick sends one zero command; then silence.
      if (halted) return 1'b0;
      for (int k = 0; k < AXES; k++) begin
        vel_goal[k]   = '0;
        vel_ramped[k] = '0;
      end
      halted = 1'b1;
    end else begin
      // The start-up wait counts ticks only until it first completes after reset.
      if (!warmed_up) begin
        if (warmup_ticks < INIT_WAIT) begin
          warmup_ticks = warmup_ticks + 1'b1;
          return 1'b0;
        end
        warmed_up = 1'b1;
      end
      halted = 1'b0;
    end

    for (int k = 0; k < AXES; k++) begin
      if (k == AXIS_LAT && !cfg_three_axis) begin
        vel_goal[k]   = '0;
        vel_ramped[k] = '0;
      end else begin
        diff = longint'(vel_goal[k]) - longint'(vel_ramped[k]);
        lim  = cfg_max_step[k];
        if (diff > lim)
          vel_ramped[k] = 32'(longint'(vel_ramped[k]) + lim);
        else if (diff < -lim)
          vel_ramped[k] = 32'(longint'(vel_ramped[k]) - lim);
        else
          vel_ramped[k] = vel_goal[k];
      end
      rv[k] = vel_ramped[k];
    end

    cmd.ramp_forward    = vel_ramped[AXIS_FWD];
    cmd.ramp_lateral    = vel_ramped[AXIS_LAT];
    cmd.ramp_turn       = vel_ramped[AXIS_TURN];
    cmd.cmd_forward_mm  = clamp16(rv[AXIS_FWD] * MM_PER_M / Q16_ONE);
    cmd.cmd_lateral_mm  = clamp16(rv[AXIS_LAT] * MM_PER_M / Q16_ONE);
    cmd.cmd_turn_deg    = clamp16(rv[AXIS_TURN] * DEG_NUM / (DEG_DEN * Q16_ONE));
    cmd.lateral_present = cfg_three_axis;
    return 1'b1;
  endfunction

  // Stick values lean toward full deflection and center now and then.
  function automatic logic signed [STICK_W-1:0] rand_stick();
    case ($urandom_range(0, 11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic joy_req_t rand_req(input logic kind, input logic deadman);
    joy_req_t r;
    r.req_type        = kind;
    r.deadman_pressed = deadman;
    r.run_pressed     = 1'($urandom_range(0, 1));
    r.stick_forward   = rand_stick();
    r.stick_lateral   = rand_stick();
    r.stick_turn      = rand_stick();
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offers one request, with random idle cycles ahead of it, and runs the
  // predictor at the edge where the transaction is accepted. Valid is left high;
  // the caller's next action in the same time step decides what it becomes.
  task automatic send_request(input joy_req_t it, output bit produced,
                              output vel_cmd_t cmd);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= it.req_type;
    req_ch.deadman_pressed <= it.deadman_pressed;
    req_ch.run_pressed     <= it.run_pressed;
    req_ch.stick_forward   <= it.stick_forward;
    req_ch.stick_lateral   <= it.stick_lateral;
    req_ch.stick_turn      <= it.stick_turn;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    produced = advance_limiter(it, cmd);
  endtask

  // Drops valid, waits for every predicted command, then lets the block finish
  // any silent transaction still in flight.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers back to back; only called while the block is idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] vals [N_REGS]);
    cfg_idx_e idx;
    for (int i = 0; i < N_REGS; i++) begin
      idx = cfg_idx_e'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      case (idx)
        CFG_THREE_AXIS:    cfg_three_axis              = vals[i][0];
        CFG_RUN_BOOST:     cfg_run_boost               = vals[i][BOOST_W-1:0];
        CFG_MAX_VEL_FWD:   cfg_max_vel[AXIS_FWD]       = vals[i][LIMIT_W-1:0];
        CFG_MAX_VEL_LAT:   cfg_max_vel[AXIS_LAT]       = vals[i][LIMIT_W-1:0];
        CFG_MAX_VEL_TURN:  cfg_max_vel[AXIS_TURN]      = vals[i][LIMIT_W-1:0];
        CFG_MAX_STEP_FWD:  cfg_max_step[AXIS_FWD]      = vals[i][LIMIT_W-1:0];
        CFG_MAX_STEP_LAT:  cfg_max_step[AXIS_LAT]      = vals[i][LIMIT_W-1:0];
        CFG_MAX_STEP_TURN: cfg_max_step[AXIS_TURN]     = vals[i][LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // The receiver stalls at random; during the no-idle phase it is always ready.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Every accepted command is compared against the oldest prediction.
  always @(posedge clk) begin : cmd_monitor
    vel_cmd_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_cmds.size() == 0) begin
        $error("command transaction with no prediction pending");
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("ramp_forward", want.ramp_forward, rsp_ch.ramp_forward);
        check_field("ramp_lateral", want.ramp_lateral, rsp_ch.ramp_lateral);
        check_field("ramp_turn", want.ramp_turn, rsp_ch.ramp_turn);
        check_field("cmd_forward_mm", want.cmd_forward_mm, rsp_ch.cmd_forward_mm);
        check_field("cmd_lateral_mm", want.cmd_lateral_mm, rsp_ch.cmd_lateral_mm);
        check_field("cmd_turn_deg", want.cmd_turn_deg, rsp_ch.cmd_turn_deg);
        check_field("lateral_present", want.lateral_present, rsp_ch.lateral_present);
        cmds_seen++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    joy_req_t                it;
    vel_cmd_t                cmd;
    vel_cmd_t                typed;
    bit                      produced;
    logic [CFG_DATA_W-1:0]   regs [N_REGS];
    joy_req_t                burst [$];
    int                      counted;
    int                      reqs_sent;
    int                      settings;
    int                      sel;

    // Predictor state after reset.
    cfg_three_axis = 1'b1;
    cfg_run_boost  = RUN_BOOST_RESET;
    for (int k = 0; k < AXES; k++) begin
      cfg_max_vel[k]  = '0;
      cfg_max_step[k] = '0;
      vel_goal[k]     = '0;
      vel_ramped[k]   = '0;
    end
    engaged      = 1'b0;
    halted       = 1'b0;
    warmed_up    = 1'b0;
    warmup_ticks = '0;
    boost_sel    = BOOST_ONE;
    reqs_sent    = 0;
    settings     = 0;

    // Directed rows. Full-scale limits and the largest boost make the first
    // ramping tick land on positive saturation on every axis; a tick while the
    // block is inactive stops it once and then goes quiet; the start-up wait
    // holds the first twenty ticks back and is not repeated on re-activation.
    dir_tab = '{
      '{1,  REQ_TICK,   1'b1, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh1234, CHK_STOP_ZERO},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_SILENT},
      '{1,  REQ_SAMPLE, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, CHK_SILENT},
      '{1,  REQ_TICK,   1'b1, 1'b0, 16'sh5555, 16'shAAAA, 16'shFFFF, CHK_SILENT},
      '{1,  REQ_SAMPLE, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, CHK_SILENT},
      '{20, REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_SILENT},
      '{1,  REQ_TICK,   1'b0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, CHK_FULL_POS},
      '{1,  REQ_TICK,   1'b1, 1'b1, 16'sh0001, 16'sh0001, 16'sh0001, CHK_FULL_POS},
      '{1,  REQ_SAMPLE, 1'b1, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, CHK_PREDICT},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_PREDICT},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_PREDICT},
      '{1,  REQ_SAMPLE, 1'b1, 1'b1, 16'sh0001, 16'shFFFF, 16'sh0000, CHK_PREDICT},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_PREDICT},
      '{1,  REQ_SAMPLE, 1'b0, 1'b0, 16'sh1234, 16'sh4321, 16'shF00F, CHK_SILENT},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_STOP_ZERO},
      '{1,  REQ_TICK,   1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, CHK_SILENT}
    };

    rst_n                  <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_SAMPLE;
    req_ch.deadman_pressed <= 1'b0;
    req_ch.run_pressed     <= 1'b0;
    req_ch.stick_forward   <= '0;
    req_ch.stick_lateral   <= '0;
    req_ch.stick_turn      <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_THREE_AXIS;
    cfg_ch.data            <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    regs[CFG_THREE_AXIS]    = 32'd1;
    regs[CFG_RUN_BOOST]     = 32'd4095;
    regs[CFG_MAX_VEL_FWD]   = 32'h7FFF_FFFF;
    regs[CFG_MAX_VEL_LAT]   = 32'h7FFF_FFFF;
    regs[CFG_MAX_VEL_TURN]  = 32'h7FFF_FFFF;
    regs[CFG_MAX_STEP_FWD]  = 32'h7FFF_FFFF;
    regs[CFG_MAX_STEP_LAT]  = 32'h7FFF_FFFF;
    regs[CFG_MAX_STEP_TURN] = 32'h7FFF_FFFF;
    write_config(regs);
    settings++;

    for (int r = 0; r < N_DIR; r++) begin
      for (int n = 0; n < dir_tab[r].reps; n++) begin
        it.req_type        = dir_tab[r].req_type;
        it.deadman_pressed = dir_tab[r].deadman;
        it.run_pressed     = dir_tab[r].run;
        it.stick_forward   = dir_tab[r].s_fwd;
        it.stick_lateral   = dir_tab[r].s_lat;
        it.stick_turn      = dir_tab[r].s_turn;
        send_request(it, produced, cmd);
        reqs_sent++;
        typed = '{default: '0};
        typed.lateral_present = 1'b1;
        case (dir_tab[r].chk)
          CHK_PREDICT: if (produced) expect_cmd(cmd);
          CHK_STOP_ZERO: expect_cmd(typed);
          CHK_FULL_POS: begin
            typed.ramp_forward   = 32'sh7FFF_FFFF;
            typed.ramp_lateral   = 32'sh7FFF_FFFF;
            typed.ramp_turn      = 32'sh7FFF_FFFF;
            typed.cmd_forward_mm = 16'sh7FFF;
            typed.cmd_lateral_mm = 16'sh7FFF;
            typed.cmd_turn_deg   = 16'sh7FFF;
            expect_cmd(typed);
          end
          default: ;
        endcase
      end
    end

    // Random phases, each under its own register setting. Phase 3 runs with no
    // idling on either side.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          // Two-axis mode, zero run boost, everything else at full scale.
          regs[CFG_THREE_AXIS] = 32'd0;
          regs[CFG_RUN_BOOST]  = 32'd0;
          for (int k = 0; k < AXES; k++) begin
            regs[CFG_MAX_VEL_FWD + k]  = 32'h7FFF_FFFF;
            regs[CFG_MAX_STEP_FWD + k] = 32'h7FFF_FFFF;
          end
        end
        1: begin
          regs[CFG_THREE_AXIS] = 32'd1;
          regs[CFG_RUN_BOOST]  = $urandom_range(256, 1024);
          for (int k = 0; k < AXES; k++) begin
            regs[CFG_MAX_VEL_FWD + k]  = $urandom_range(0, 1 << 18);
            regs[CFG_MAX_STEP_FWD + k] = $urandom_range(0, 1 << 14);
          end
        end
        2: begin
          // Zero step: ramps only move through a stop.
          regs[CFG_THREE_AXIS]   = 32'd1;
          regs[CFG_RUN_BOOST]    = 32'd4095;
          regs[CFG_MAX_VEL_FWD]  = 32'd0;
          regs[CFG_MAX_VEL_LAT]  = $urandom & 32'h7FFF_FFFF;
          regs[CFG_MAX_VEL_TURN] = 32'h7FFF_FFFF;
          for (int k = 0; k < AXES; k++) regs[CFG_MAX_STEP_FWD + k] = 32'd0;
        end
        3: begin
          // Raw 32-bit words: the unused upper bits must be dropped.
          for (int i = 0; i < N_REGS; i++) regs[i] = $urandom;
        end
        4: begin
          regs[CFG_THREE_AXIS] = 32'd0;
          regs[CFG_RUN_BOOST]  = $urandom_range(0, 4095);
          for (int k = 0; k < AXES; k++) begin
            regs[CFG_MAX_VEL_FWD + k]  = $urandom_range(1 << 14, 1 << 18);
            regs[CFG_MAX_STEP_FWD + k] = $urandom_range(1 << 10, 1 << 15);
          end
        end
        default: begin
          regs[CFG_THREE_AXIS] = 32'd1;
          regs[CFG_RUN_BOOST]  = BOOST_ONE;
          for (int k = 0; k < AXES; k++) begin
            regs[CFG_MAX_VEL_FWD + k]  = $urandom_range(0, 1 << 20);
            regs[CFG_MAX_STEP_FWD + k] = $urandom_range(1, 1 << 16);
          end
        end
      endcase
      write_config(regs);
      settings++;
      idle_pct = (p == 3) ? 0 : IDLE_PCT;

      counted = 0;
      while (counted < PER_PHASE) begin
        // Mostly a held-deadman sample followed by a run of ticks; some
        // releases followed by ticks; the rest is unstructured noise.
        burst.delete();
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          burst = {burst, rand_req(REQ_SAMPLE, 1'b1)};
          repeat ($urandom_range(1, 6))
            burst = {burst, rand_req(REQ_TICK, 1'($urandom_range(0, 1)))};
        end else if (sel < 85) begin
          burst = {burst, rand_req(REQ_SAMPLE, 1'b0)};
          repeat ($urandom_range(1, 3))
            burst = {burst, rand_req(REQ_TICK, 1'($urandom_range(0, 1)))};
        end else begin
          burst = {burst, rand_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)))};
        end
        foreach (burst[i]) begin
          send_request(burst[i], produced, cmd);
          reqs_sent++;
          if (produced) expect_cmd(cmd);
          // Silent ticks produce no command and do not count toward the phase.
          if (burst[i].req_type == REQ_SAMPLE || produced) counted++;
        end
        // Now and then the sender holds off until every command is out.
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("Sent %0d requests under %0d register settings; compared %0d commands.",
             reqs_sent, settings, cmds_seen);
    $display("Settings spanned both axis modes, zero and full-scale limits and boosts.");
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tvrl_pkg.sv
design/tvrl_if.sv
design/tvrl_dp.sv
design/tvrl_ctrl.sv
design/teleop_velocity_ramp_limiter.sv
dv/teleop_velocity_ramp_limiter_test.sv
